// ===== hw/rtl/tir_pkg.sv =====
// Shared types and constants of the tick interval resampler.
`timescale 1ns / 1ps
`default_nettype none
package tir_pkg;

  localparam int unsigned TimeWidth   = 63;
  localparam int unsigned PriceWidth  = 40;
  localparam int unsigned TickVolWidth = 40;
  localparam int unsigned BarVolWidth = 48;
  localparam int unsigned IntvWidth   = 40;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueueIdxWidth = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

  localparam logic [IntvWidth-1:0] IntervalReset = 40'd1000000000;

  typedef struct packed {
    logic [TimeWidth-1:0]   start;
    logic [PriceWidth-1:0]  price;
    logic [BarVolWidth-1:0] volume;
  } bar_t;

  // One queue entry holds the bars that one tick causes: one, or two when
  // a closing tick also ends the series.
  typedef struct packed {
    bar_t first;
    bar_t second;
    logic two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tick_interval_resampler.sv =====
// Top level of the tick interval resampler.
//
// Channel  Direction  Handshake               Payload
// cfg      in         cfg_valid_i/cfg_ready_o bucket interval, 40 bits
// tick     in         tick_valid_i/tick_stall_o time, price, volume, end flag
// bar      out        bar_valid_o/bar_stall_i start, price, volume, last flag
//
// One tick is taken every cycle while the four-entry bar queue has room.
// A bar is queued at the edge that takes its tick and then loaded into the output register.
// A tick that closes a bucket and ends the series gives two bars in turn from one output register.
// Reset clears the bucket state, the queue and the interval to one second.
// A stalled output fills the queue and then stalls the tick channel.
`timescale 1ns / 1ps
`default_nettype none
module tick_interval_resampler (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tir_pkg::IntvWidth-1:0]    cfg_data_i,
  input  wire logic                             tick_valid_i,
  output logic                                  tick_stall_o,
  input  wire logic [tir_pkg::TimeWidth-1:0]    tick_time_i,
  input  wire logic [tir_pkg::PriceWidth-1:0]   tick_price_i,
  input  wire logic [tir_pkg::TickVolWidth-1:0] tick_volume_i,
  input  wire logic                             end_of_series_i,
  output logic                                  bar_valid_o,
  input  wire logic                             bar_stall_i,
  output logic [tir_pkg::TimeWidth-1:0]         bar_start_o,
  output logic [tir_pkg::PriceWidth-1:0]        bar_price_o,
  output logic [tir_pkg::BarVolWidth-1:0]       bar_volume_o,
  output logic                                  last_of_run_o
);
  import tir_pkg::*;

  entry_t        push_entry;
  entry_t        head_entry;
  queue_status_t status;
  logic          push;
  logic          pop;
  logic          tick_fire;
  bar_t          bar;

  assign cfg_ready_o  = 1'b1;
  assign tick_stall_o = status.full;
  assign tick_fire    = tick_valid_i && !status.full;

  tir_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .tick_fire_i     (tick_fire),
    .tick_time_i     (tick_time_i),
    .tick_price_i    (tick_price_i),
    .tick_volume_i   (tick_volume_i),
    .end_of_series_i (end_of_series_i),
    .entry_o         (push_entry),
    .push_o          (push)
  );

  tir_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (status)
  );

  tir_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .status_i      (status),
    .pop_o         (pop),
    .bar_valid_o   (bar_valid_o),
    .bar_stall_i   (bar_stall_i),
    .bar_o         (bar),
    .last_of_run_o (last_of_run_o)
  );

  assign bar_start_o  = bar.start;
  assign bar_price_o  = bar.price;
  assign bar_volume_o = bar.volume;

endmodule
`default_nettype wire

// ===== hw/rtl/tir_front.sv =====
// Front part: accepts ticks, keeps the open bucket and queues finished bars.
`timescale 1ns / 1ps
`default_nettype none
module tir_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [tir_pkg::IntvWidth-1:0]  cfg_data_i,
  input  wire logic                           tick_fire_i,
  input  wire logic [tir_pkg::TimeWidth-1:0]  tick_time_i,
  input  wire logic [tir_pkg::PriceWidth-1:0] tick_price_i,
  input  wire logic [tir_pkg::TickVolWidth-1:0] tick_volume_i,
  input  wire logic                           end_of_series_i,
  output tir_pkg::entry_t                     entry_o,
  output logic                                push_o
);
  import tir_pkg::*;

  logic [IntvWidth-1:0]   interval_q;
  logic                   started_q, started_d;
  logic [TimeWidth-1:0]   start_q, start_d;
  logic [TimeWidth-1:0]   end_q, end_d;
  logic [PriceWidth-1:0]  price_q, price_d;
  logic [BarVolWidth-1:0] vol_q, vol_d;

  logic [TimeWidth:0]     open_sum;
  logic [TimeWidth:0]     next_sum;
  logic [BarVolWidth:0]   vol_sum;
  logic [TimeWidth-1:0]   open_end;
  logic [TimeWidth-1:0]   next_end;
  logic [BarVolWidth-1:0] vol_acc;
  logic                   close;
  bar_t                   old_bar;
  bar_t                   new_bar;

  assign open_sum = {1'b0, tick_time_i} + {{(TimeWidth + 1 - IntvWidth){1'b0}}, interval_q};
  assign next_sum = {1'b0, end_q} + {{(TimeWidth + 1 - IntvWidth){1'b0}}, interval_q};
  assign vol_sum  = {1'b0, vol_q} + {{(BarVolWidth + 1 - TickVolWidth){1'b0}}, tick_volume_i};
  assign open_end = open_sum[TimeWidth] ? {TimeWidth{1'b1}} : open_sum[TimeWidth-1:0];
  assign next_end = next_sum[TimeWidth] ? {TimeWidth{1'b1}} : next_sum[TimeWidth-1:0];
  assign vol_acc  = vol_sum[BarVolWidth] ? {BarVolWidth{1'b1}} : vol_sum[BarVolWidth-1:0];

  assign close = started_q && (tick_time_i >= end_q);

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    price_d = tick_price_i;
    vol_d   = {{(BarVolWidth - TickVolWidth){1'b0}}, tick_volume_i};
    if (!started_q) begin
      start_d = tick_time_i;
      end_d   = open_end;
    end else if (close) begin
      start_d = end_q;
      end_d   = next_end;
    end else begin
      vol_d = vol_acc;
    end
  end

  assign old_bar = '{start: start_q, price: price_q, volume: vol_q};
  assign new_bar = '{start: start_d, price: price_d, volume: vol_d};

  always_comb begin
    entry_o.first  = close ? old_bar : new_bar;
    entry_o.second = new_bar;
    entry_o.two    = close && end_of_series_i;
  end

  assign push_o    = tick_fire_i && (close || end_of_series_i);
  assign started_d = !end_of_series_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
      started_q  <= 1'b0;
      start_q    <= '0;
      end_q      <= '0;
      price_q    <= '0;
      vol_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        interval_q <= cfg_data_i;
      end
      if (tick_fire_i) begin
        started_q <= started_d;
        if (end_of_series_i) begin
          start_q <= '0;
          end_q   <= '0;
          price_q <= '0;
          vol_q   <= '0;
        end else begin
          start_q <= start_d;
          end_q   <= end_d;
          price_q <= price_d;
          vol_q   <= vol_d;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tir_queue.sv =====
// Short queue of bar entries between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none
module tir_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  tir_pkg::entry_t       entry_i,
  input  wire logic             pop_i,
  output tir_pkg::entry_t       entry_o,
  output tir_pkg::queue_status_t status_o
);
  import tir_pkg::*;

  entry_t                   slots_q [QueueDepth];
  logic [QueueIdxWidth-1:0] wr_ptr_q;
  logic [QueueIdxWidth-1:0] rd_ptr_q;
  logic [QueueCntWidth-1:0] count_q;
  logic                     do_push;
  logic                     do_pop;

  assign status_o.full  = (count_q == QueueCntWidth'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueueIdxWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueueIdxWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tir_back.sv =====
// Back part: unpacks queued entries into bars and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module tir_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  tir_pkg::entry_t        entry_i,
  input  tir_pkg::queue_status_t status_i,
  output logic                   pop_o,
  output logic                   bar_valid_o,
  input  wire logic              bar_stall_i,
  output tir_pkg::bar_t          bar_o,
  output logic                   last_of_run_o
);
  import tir_pkg::*;

  logic valid_q;
  logic second_q;
  logic last_q;
  bar_t bar_q;
  logic load;

  assign load  = !valid_q || !bar_stall_i;
  assign pop_o = load && !status_i.empty && (second_q || !entry_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load) begin
      valid_q <= !status_i.empty;
      if (!status_i.empty) begin
        second_q <= entry_i.two && !second_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !status_i.empty) begin
      bar_q  <= second_q ? entry_i.second : entry_i.first;
      last_q <= second_q || !entry_i.two;
    end
  end

  assign bar_valid_o   = valid_q;
  assign bar_o         = bar_q;
  assign last_of_run_o = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tir_checker.sv =====
// Port-level checks of the tick interval resampler and their binding.
`timescale 1ns / 1ps
`default_nettype none
module tir_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             bar_valid_o,
  input wire logic                             bar_stall_i,
  input wire logic [tir_pkg::TimeWidth-1:0]    bar_start_o,
  input wire logic [tir_pkg::PriceWidth-1:0]   bar_price_o,
  input wire logic [tir_pkg::BarVolWidth-1:0]  bar_volume_o,
  input wire logic                             last_of_run_o
);
  import tir_pkg::*;

  logic bar_xfer;
  assign bar_xfer = bar_valid_o && !bar_stall_i;

  // A stalled bar holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bar_valid_o && bar_stall_i |=> bar_valid_o && $stable(bar_start_o) &&
      $stable(bar_price_o) && $stable(bar_volume_o) && $stable(last_of_run_o))
    else $error("stalled bar changed");

  // The second bar of a pair follows the first in the next cycle.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bar_xfer && !last_of_run_o |=> bar_valid_o && last_of_run_o)
    else $error("second bar of a pair missing");

  // The flushed bucket of a pair never starts before the closed one.
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bar_xfer && !last_of_run_o |=> bar_start_o >= $past(bar_start_o))
    else $error("second bar starts before the first");

  // No bar is offered straight out of reset.
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !bar_valid_o)
    else $error("bar offered straight after reset");

endmodule

bind tick_interval_resampler tir_checker u_tir_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .bar_valid_o   (bar_valid_o),
  .bar_stall_i   (bar_stall_i),
  .bar_start_o   (bar_start_o),
  .bar_price_o   (bar_price_o),
  .bar_volume_o  (bar_volume_o),
  .last_of_run_o (last_of_run_o)
);
`default_nettype wire
